[sv/nsf_pkg.sv]
// Shared types, phase codes and character constants for the NMEA sentence framer.
package nsf_pkg;

	localparam int BODY_LIMIT = 256;
	localparam int LEN_W      = $clog2(BODY_LIMIT);

	// Parser phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_HEX1 = 2'd2;
	localparam logic [1:0] PH_HEX2 = 2'd3;

	// Sentence kind codes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_RMC   = 2'd1;
	localparam logic [1:0] KIND_GGA   = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	// Message flag bit positions
	localparam int FLAG_RMC = 0;
	localparam int FLAG_GGA = 1;
	localparam int FLAG_NEW = 2;

	// Characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;

	localparam logic [23:0] TYPE_RMC = 24'h524D43;
	localparam logic [23:0] TYPE_GGA = 24'h474741;

	localparam logic [1:0] TYPE_FIRST = 2'd2;
	localparam logic [2:0] TYPE_LAST  = 3'd4;
	localparam logic [2:0] TYPED_LEN  = 3'd5;

	typedef struct packed {
		logic [1:0]       phase;
		logic [LEN_W-1:0] body_length;
		logic [7:0]       running_checksum;
		logic [3:0]       high_nibble;
		logic [23:0]      type_letters;
		logic [2:0]       message_flags;
		logic             chunk_seen;
	} state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       chunk_end;
	} item_t;

	typedef struct packed {
		logic [1:0] sentence_kind;
		logic       checksum_error;
		logic [2:0] flags_out;
		logic       chunk_found;
	} result_t;

endpackage

[sv/nsf_step.sv]
// Per-byte parser step: next parser state and result from the current state and one byte.
module nsf_step (
	input  nsf_pkg::state_t  st,
	input  nsf_pkg::item_t   item,
	output nsf_pkg::state_t  st_next,
	output nsf_pkg::result_t res
);
	import nsf_pkg::*;

	// Decode one hex digit; bit 4 set means not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c inside {[8'h30:8'h39]}) begin
			v = {1'b0, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

	logic [4:0] hex;
	logic       typed;
	logic [2:0] flags_upd;

	assign hex   = hex_value(item.data_byte);
	assign typed = st.body_length >= LEN_W'(TYPED_LEN);

	always_comb begin
		st_next   = st;
		res       = '0;
		flags_upd = st.message_flags;
		if (item.cmd) begin
			// Clear flags only; parser and chunk tracking hold
			st_next.message_flags = '0;
		end else begin
			case (st.phase)
				PH_IDLE: begin
					if (item.data_byte == CH_DOLLAR) begin
						st_next.phase            = PH_BODY;
						st_next.body_length      = '0;
						st_next.running_checksum = '0;
						st_next.high_nibble      = '0;
						st_next.type_letters     = '0;
					end
				end
				PH_BODY: begin
					if (item.data_byte == CH_STAR) begin
						st_next.phase = PH_HEX1;
					end else if (item.data_byte inside {[CH_SPACE:CH_LOW_Z]}) begin
						if (st.body_length >= LEN_W'(BODY_LIMIT - 1)) begin
							st_next.phase = PH_IDLE;
						end else begin
							// Keep body characters three to five as the type
							if (st.body_length >= LEN_W'(TYPE_FIRST)
									&& st.body_length <= LEN_W'(TYPE_LAST)) begin
								st_next.type_letters = {st.type_letters[15:0], item.data_byte};
							end
							st_next.running_checksum = st.running_checksum ^ item.data_byte;
							st_next.body_length      = st.body_length + LEN_W'(1);
						end
					end else begin
						st_next.phase = PH_IDLE;
					end
				end
				PH_HEX1: begin
					if (!hex[4]) begin
						st_next.high_nibble = hex[3:0];
						st_next.phase       = PH_HEX2;
					end else begin
						st_next.phase = PH_IDLE;
					end
				end
				default: begin
					// Compare the received checksum and class the sentence
					if (!hex[4]) begin
						if ({st.high_nibble, hex[3:0]} == st.running_checksum) begin
							if (typed && st.type_letters == TYPE_RMC) begin
								res.sentence_kind    = KIND_RMC;
								flags_upd[FLAG_RMC]  = 1'b1;
								st_next.chunk_seen   = 1'b1;
							end else if (typed && st.type_letters == TYPE_GGA) begin
								res.sentence_kind    = KIND_GGA;
								flags_upd[FLAG_GGA]  = 1'b1;
								st_next.chunk_seen   = 1'b1;
							end else begin
								res.sentence_kind = KIND_OTHER;
							end
							if (flags_upd[FLAG_RMC] && flags_upd[FLAG_GGA]) begin
								flags_upd[FLAG_NEW] = 1'b1;
							end
							st_next.message_flags = flags_upd;
						end else begin
							res.checksum_error = 1'b1;
						end
					end
					st_next.phase = PH_IDLE;
				end
			endcase
			// Report and restart chunk tracking on the last byte of a chunk
			if (item.chunk_end) begin
				res.chunk_found    = st_next.chunk_seen;
				st_next.chunk_seen = 1'b0;
			end
		end
		res.flags_out = st_next.message_flags;
	end

endmodule

[sv/nmea_sentence_framer.sv]
// Top level of the NMEA sentence framer: input register, parser state and result register.
// The framer takes one NMEA character per beat and returns one result beat for each:
// the sentence class when a checksum completes, a checksum error flag, the sticky RMC/GGA
// and group-complete flags, and the chunk-found bit on the last byte of a chunk. It sustains
// one byte per clock cycle while the result side is not stalled; the single-pass parser
// step sits between the input register and the result register. A command beat clears
// the sticky flags without disturbing a sentence in progress.
module nmea_sentence_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	input  logic       chunk_end,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] sentence_kind,
	output logic       checksum_error,
	output logic [2:0] flags_out,
	output logic       chunk_found
);
	import nsf_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	state_t  state_q;
	state_t  state_next;
	result_t res_next;
	logic    adv_s1;
	logic    adv_s2;

	// Advance when the result register is empty or being drained
	assign adv_s2     = !valid_s2 || result_ready;
	assign adv_s1     = valid_s1 && adv_s2;
	assign item_ready = !valid_s1 || adv_s2;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= '{cmd: cmd, data_byte: data_byte, chunk_end: chunk_end};
		end
	end

	nsf_step u_step (
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res_next)
	);

	// Parser state: update once per byte that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid   = valid_s2;
	assign sentence_kind  = res_s2.sentence_kind;
	assign checksum_error = res_s2.checksum_error;
	assign flags_out      = res_s2.flags_out;
	assign chunk_found    = res_s2.chunk_found;

`ifndef SYNTH
	// A classified sentence never carries a checksum error
	a_kind_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && sentence_kind != KIND_NONE |-> !checksum_error)
		else $error("sentence kind reported together with checksum error");

	// The group bit needs both RMC and GGA seen
	a_group_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && flags_out[FLAG_NEW] |-> flags_out[FLAG_RMC] && flags_out[FLAG_GGA])
		else $error("group flag set without both sentence flags");

	// An accepted RMC or GGA shows in the flags of the same beat
	a_kind_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (sentence_kind == KIND_RMC || sentence_kind == KIND_GGA)
		|-> flags_out[sentence_kind - 2'd1])
		else $error("accepted sentence missing from flags");

	// A completed checksum returns the parser to idle
	a_idle_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (res_next.sentence_kind != KIND_NONE || res_next.checksum_error)
		|=> state_q.phase == PH_IDLE)
		else $error("parser not idle after checksum");
`endif

endmodule

[tb/nmea_sentence_framer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the NMEA sentence framer: sentence stimulus, flow control, checking.
module nmea_sentence_framer_tb;
	import nsf_pkg::*;

	localparam int TARGET_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	typedef enum int {PICK_RMC, PICK_GGA, PICK_ANY} type_pick_e;
	typedef enum int {SEND_GOOD, SEND_BAD_SUM, SEND_BAD_HEX1, SEND_BAD_HEX2, SEND_CUT} flavor_e;
	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_e;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       item_valid     = 1'b0;
	logic       item_ready;
	logic       cmd            = 1'b0;
	logic [7:0] data_byte      = 8'h00;
	logic       chunk_end      = 1'b0;
	logic       result_valid;
	logic       result_ready   = 1'b0;
	logic [1:0] sentence_kind;
	logic       checksum_error;
	logic [2:0] flags_out;
	logic       chunk_found;

	// Framer state as predicted from the accepted bytes
	logic [1:0]       parse_phase = PH_IDLE;
	logic [LEN_W-1:0] body_count  = '0;
	logic [7:0]       xor_sum     = '0;
	logic [3:0]       hi_digit    = '0;
	logic [23:0]      type_tag    = '0;
	logic [2:0]       msg_flags   = '0;
	logic             chunk_hit   = 1'b0;

	item_t   pending_items[$];
	result_t expected_results[$];

	int       useful_items   = 0;
	bit       mix_clears     = 1'b0;
	int       burst_left     = 1;
	int       gap_left       = 0;
	rx_mode_e rx_mode        = RX_OPEN;
	int       rx_left        = 0;
	int       mismatch_count = 0;
	int       cycle_count    = 0;

	nmea_sentence_framer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.chunk_end     (chunk_end),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.sentence_kind (sentence_kind),
		.checksum_error(checksum_error),
		.flags_out     (flags_out),
		.chunk_found   (chunk_found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Hex digit of either case: bit 4 marks a valid digit, bits 3..0 its value
	function automatic logic [4:0] decode_hex(input logic [7:0] ch);
		logic [7:0] v;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			v = ch - 8'h30;
			return {1'b1, v[3:0]};
		end
		if (ch >= 8'h61 && ch <= 8'h66) begin
			v = ch - 8'h57;
			return {1'b1, v[3:0]};
		end
		if (ch >= 8'h41 && ch <= 8'h46) begin
			v = ch - 8'h37;
			return {1'b1, v[3:0]};
		end
		return 5'b0;
	endfunction

	// Advance the predicted framer by one accepted beat and return its result
	function automatic result_t framer_step(input item_t it);
		result_t    r;
		logic [4:0] hx;
		logic [7:0] ch;
		r  = '0;
		ch = it.data_byte;
		if (it.cmd) begin
			msg_flags = '0;
			return r;
		end
		case (parse_phase)
			PH_IDLE: begin
				if (ch == CH_DOLLAR) begin
					parse_phase = PH_BODY;
					body_count  = '0;
					xor_sum     = '0;
					hi_digit    = '0;
					type_tag    = '0;
				end
			end
			PH_BODY: begin
				if (ch == CH_STAR) begin
					parse_phase = PH_HEX1;
				end else if (ch >= CH_SPACE && ch <= CH_LOW_Z) begin
					if (body_count >= BODY_LIMIT - 1) begin
						parse_phase = PH_IDLE;
					end else begin
						if (body_count >= TYPE_FIRST && body_count <= TYPE_LAST)
							type_tag = {type_tag[15:0], ch};
						xor_sum    = xor_sum ^ ch;
						body_count = body_count + 1'b1;
					end
				end else begin
					parse_phase = PH_IDLE;
				end
			end
			PH_HEX1: begin
				hx = decode_hex(ch);
				if (hx[4]) begin
					hi_digit    = hx[3:0];
					parse_phase = PH_HEX2;
				end else begin
					parse_phase = PH_IDLE;
				end
			end
			default: begin
				hx = decode_hex(ch);
				if (hx[4]) begin
					if ({hi_digit, hx[3:0]} == xor_sum) begin
						if (body_count >= TYPED_LEN && type_tag == TYPE_RMC) begin
							r.sentence_kind     = KIND_RMC;
							msg_flags[FLAG_RMC] = 1'b1;
							chunk_hit           = 1'b1;
						end else if (body_count >= TYPED_LEN && type_tag == TYPE_GGA) begin
							r.sentence_kind     = KIND_GGA;
							msg_flags[FLAG_GGA] = 1'b1;
							chunk_hit           = 1'b1;
						end else begin
							r.sentence_kind = KIND_OTHER;
						end
						if (msg_flags[FLAG_RMC] && msg_flags[FLAG_GGA])
							msg_flags[FLAG_NEW] = 1'b1;
					end else begin
						r.checksum_error = 1'b1;
					end
				end
				parse_phase = PH_IDLE;
			end
		endcase
		if (it.chunk_end) begin
			r.chunk_found = chunk_hit;
			chunk_hit     = 1'b0;
		end
		r.flags_out = msg_flags;
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + n;
		return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	// Body character: never '*', with extra weight on '$'
	function automatic logic [7:0] body_char();
		logic [7:0] ch;
		if ($urandom_range(0, 19) == 0)
			return CH_DOLLAR;
		do
			ch = 8'($urandom_range(CH_SPACE, CH_LOW_Z));
		while (ch == CH_STAR);
		return ch;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] ch;
		logic [4:0] hx;
		do begin
			ch = 8'($urandom_range(0, 255));
			hx = decode_hex(ch);
		end while (hx[4]);
		return ch;
	endfunction

	task automatic push_clear();
		logic [7:0] junk;
		logic       junk_end;
		junk     = 8'($urandom_range(0, 255));
		junk_end = 1'($urandom_range(0, 1));
		pending_items.push_back({1'b1, junk, junk_end});
		useful_items++;
	endtask

	// Queue one data beat, now and then preceded by a flag clear
	task automatic push_byte(input logic [7:0] ch, input logic last);
		if (mix_clears && $urandom_range(0, 59) == 0)
			push_clear();
		pending_items.push_back({1'b0, ch, last});
		useful_items++;
	endtask

	// Queue one sentence: '$', body, '*', two hex digits, broken as the flavor says
	task automatic send_sentence(input int body_len, input type_pick_e pick,
			input flavor_e flavor, input bit close_chunk, input bit scatter);
		logic [7:0]  body[$];
		logic [7:0]  sum;
		logic [7:0]  sent_sum;
		logic [7:0]  flip;
		logic [23:0] tag;
		int          cut_at;
		tag = (pick == PICK_RMC) ? TYPE_RMC : TYPE_GGA;
		sum = '0;
		for (int i = 0; i < body_len; i++) begin
			if (pick != PICK_ANY && i >= 2 && i <= 4)
				body.push_back(tag[8*(4-i) +: 8]);
			else
				body.push_back(body_char());
			sum = sum ^ body[i];
		end
		cut_at = (flavor == SEND_CUT) ? int'($urandom_range(0, body_len)) : -1;
		push_byte(CH_DOLLAR, scatter && ($urandom_range(0, 9) == 0));
		for (int i = 0; i <= body_len; i++) begin
			if (i == cut_at) begin
				if ($urandom_range(0, 1) != 0)
					push_byte(8'($urandom_range(0, 8'h1F)), close_chunk);
				else
					push_byte(8'($urandom_range(8'h7B, 8'hFF)), close_chunk);
				return;
			end
			if (i < body_len)
				push_byte(body[i], scatter && ($urandom_range(0, 9) == 0));
		end
		push_byte(CH_STAR, scatter && ($urandom_range(0, 9) == 0));
		sent_sum = sum;
		if (flavor == SEND_BAD_SUM) begin
			flip     = 8'($urandom_range(1, 255));
			sent_sum = sent_sum ^ flip;
		end
		if (flavor == SEND_BAD_HEX1) begin
			push_byte(non_hex_byte(), close_chunk);
			return;
		end
		push_byte(hex_char(sent_sum[7:4]), scatter && ($urandom_range(0, 9) == 0));
		if (flavor == SEND_BAD_HEX2)
			push_byte(non_hex_byte(), close_chunk);
		else
			push_byte(hex_char(sent_sum[3:0]), close_chunk);
	endtask

	task automatic report_failure(input string what, input result_t want, input result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected kind=%0d err=%0d flags=%0d found=%0d,",
				$time, what, want.sentence_kind, want.checksum_error, want.flags_out,
				want.chunk_found, " got kind=%0d err=%0d flags=%0d found=%0d",
				got.sentence_kind, got.checksum_error, got.flags_out, got.chunk_found);
	endtask

	// Feed beats in bursts; predict each beat as it is accepted
	always @(posedge clk or negedge arst_n) begin : feed
		item_t next_item;
		if (!arst_n) begin
			item_valid <= 1'b0;
			cmd        <= 1'b0;
			data_byte  <= 8'h00;
			chunk_end  <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(framer_step({cmd, data_byte, chunk_end}));
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item  = pending_items.pop_front();
					cmd        <= next_item.cmd;
					data_byte  <= next_item.data_byte;
					chunk_end  <= next_item.chunk_end;
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						if ($urandom_range(0, 3) == 0) begin
							burst_left <= $urandom_range(40, 200);
							gap_left   <= 0;
						end else begin
							burst_left <= $urandom_range(1, 12);
							gap_left   <= $urandom_range(1, 6);
						end
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Check result beats against the oldest prediction; stall on a changing pattern
	always @(posedge clk or negedge arst_n) begin : collect
		result_t got;
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				got = {sentence_kind, checksum_error, flags_out, chunk_found};
				if (expected_results.size() == 0) begin
					report_failure("result with nothing pending", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got.sentence_kind !== want.sentence_kind
							|| got.checksum_error !== want.checksum_error
							|| got.flags_out !== want.flags_out
							|| got.chunk_found !== want.chunk_found)
						report_failure("wrong result fields", want, got);
				end
			end
			if (rx_left == 0) begin
				rx_mode <= rx_mode_e'($urandom_range(0, 3));
				rx_left <= $urandom_range(16, 80);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:     result_ready <= 1'b1;
				RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: result_ready <= (rx_left % 3 != 0);
				default:     result_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin : stimulus
		int         sent_idx;
		int         long_a;
		int         long_b;
		int         len;
		int         r;
		type_pick_e pick;
		flavor_e    flavor;
		logic [7:0] noise;
		logic       noise_end;

		// Directed: byte extremes in idle, RMC then GGA for the group bit,
		// a flag clear, and a body too short to carry a type
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		send_sentence(5, PICK_RMC, SEND_GOOD, 1'b1, 1'b0);
		send_sentence(5, PICK_GGA, SEND_GOOD, 1'b1, 1'b0);
		push_clear();
		send_sentence(1, PICK_ANY, SEND_GOOD, 1'b0, 1'b0);

		// Random sentences; one body at the length limit and one just past it
		mix_clears   = 1'b1;
		useful_items = 0;
		sent_idx     = 0;
		long_a       = $urandom_range(2, 8);
		long_b       = $urandom_range(9, 16);
		while (useful_items < TARGET_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					noise     = 8'($urandom_range(0, 255));
					noise_end = ($urandom_range(0, 7) == 0);
					pending_items.push_back({1'b0, noise, noise_end});
				end
			end
			if (sent_idx == long_a)
				len = BODY_LIMIT - 1;
			else if (sent_idx == long_b)
				len = BODY_LIMIT;
			else if ($urandom_range(0, 5) == 0)
				len = $urandom_range(0, 4);
			else
				len = $urandom_range(5, 24);
			r    = $urandom_range(0, 99);
			pick = (r < 35) ? PICK_RMC : (r < 70) ? PICK_GGA : PICK_ANY;
			r    = $urandom_range(0, 99);
			flavor = (r < 60) ? SEND_GOOD : (r < 72) ? SEND_BAD_SUM :
				(r < 80) ? SEND_BAD_HEX1 : (r < 88) ? SEND_BAD_HEX2 : SEND_CUT;
			send_sentence(len, pick, flavor, 1'($urandom_range(0, 1)), 1'b1);
			sent_idx++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all beats accepted and every prediction answered
		while ((pending_items.size() != 0 || item_valid || expected_results.size() != 0)
				&& cycle_count < CYCLE_LIMIT)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (cycle_count >= CYCLE_LIMIT || expected_results.size() != 0)
			$display("nmea_sentence_framer: mismatch");
		else if (mismatch_count == 0)
			$display("nmea_sentence_framer: match");
		else
			$display("nmea_sentence_framer: mismatch");
		$finish;
	end

endmodule
